@@ rtl/assert_macros.svh @@
// Assertion macros shared by the deframer RTL.
// Uses the including module's clk and rst; compiled out under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed: same-cycle check");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");
`else
`define ASSERT_IMPL(lbl, prop)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/sld_pkg.sv @@
// Types and constants for the sync/length/xor deframer.
// No dependencies; imported by every module of the block.
package sld_pkg;

  localparam logic [31:0] SYNC_WORD_RESET = 32'd1431193938;
  localparam logic [7:0]  DELIM_RESET     = 8'd58;

  // Configuration register indexes
  localparam logic REG_SYNC_WORD = 1'b0;
  localparam logic REG_DELIM     = 1'b1;

  typedef enum logic [6:0] {
    PH_HUNT  = 7'b0000001,
    PH_SYNC1 = 7'b0000010,
    PH_SYNC2 = 7'b0000100,
    PH_SYNC3 = 7'b0001000,
    PH_LEN   = 7'b0010000,
    PH_DELIM = 7'b0100000,
    PH_BODY  = 7'b1000000
  } phase_t;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_PAYLOAD = 2'd1,
    ST_GOOD    = 2'd2,
    ST_BAD     = 2'd3
  } status_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] frame_length;
  } result_t;

endpackage

@@ rtl/sld_core.sv @@
// Frame state machine, checksum and configuration registers of the deframer.
// Depends on sld_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sld_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [31:0]     cfg_data,
  input  logic            accept,
  input  logic [7:0]      in_byte,
  output sld_pkg::result_t res
);
  import sld_pkg::*;

  logic [31:0] sync_word;
  logic [7:0]  delimiter_byte;

  phase_t     phase, phase_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] running_xor, running_xor_next;
  logic [7:0] write_index, write_index_next;
  logic [7:0] count_dec;
  phase_t     hunt_phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_word      <= SYNC_WORD_RESET;
      delimiter_byte <= DELIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYNC_WORD: sync_word      <= cfg_data;
        REG_DELIM:     delimiter_byte <= cfg_data[7:0];
        default:       ;
      endcase
    end
  end

  assign hunt_phase = (in_byte == sync_word[31:24]) ? PH_SYNC1 : PH_HUNT;
  assign count_dec  = bytes_left - 8'd1;

  always_comb begin
    phase_next       = phase;
    bytes_left_next  = bytes_left;
    running_xor_next = running_xor;
    write_index_next = write_index;
    res              = '0;
    res.status       = ST_NONE;
    case (phase)
      PH_SYNC1: phase_next = (in_byte == sync_word[23:16]) ? PH_SYNC2 : hunt_phase;
      PH_SYNC2: phase_next = (in_byte == sync_word[15:8])  ? PH_SYNC3 : hunt_phase;
      PH_SYNC3: phase_next = (in_byte == sync_word[7:0])   ? PH_LEN   : hunt_phase;
      PH_LEN: begin
        bytes_left_next = in_byte;
        phase_next      = PH_DELIM;
      end
      PH_DELIM: begin
        if (in_byte == delimiter_byte) begin
          phase_next       = PH_BODY;
          write_index_next = 8'd0;
          running_xor_next = sync_word[31:24] ^ sync_word[23:16] ^ sync_word[15:8] ^
                             sync_word[7:0] ^ delimiter_byte ^ bytes_left;
        end else begin
          phase_next = hunt_phase;
        end
      end
      PH_BODY: begin
        bytes_left_next = count_dec;
        if (count_dec != 8'd0) begin
          res.status        = ST_PAYLOAD;
          res.payload_byte  = in_byte;
          res.payload_index = write_index;
          write_index_next  = write_index + 8'd1;
          running_xor_next  = running_xor ^ in_byte;
        end else begin
          // check byte ends the frame
          phase_next       = PH_HUNT;
          res.status       = (running_xor == in_byte) ? ST_GOOD : ST_BAD;
          res.frame_length = write_index;
        end
      end
      default: phase_next = hunt_phase;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      bytes_left  <= 8'd0;
      running_xor <= 8'd0;
      write_index <= 8'd0;
    end else if (accept) begin
      phase       <= phase_next;
      bytes_left  <= bytes_left_next;
      running_xor <= running_xor_next;
      write_index <= write_index_next;
    end
  end

  `ASSERT_IMPL(a_payload_only_in_body, (accept && res.status == ST_PAYLOAD) |-> (phase == PH_BODY))
  `ASSERT_NEXT(a_delim_starts_body, accept && phase == PH_DELIM && in_byte == delimiter_byte, phase == PH_BODY && write_index == 8'd0)
  `ASSERT_NEXT(a_frame_end_hunts, accept && (res.status == ST_GOOD || res.status == ST_BAD), phase == PH_HUNT)

endmodule

@@ rtl/sld_outbuf.sv @@
// Two-entry output buffer (result register plus skid) of the deframer.
// Depends on sld_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sld_outbuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sld_pkg::result_t in_res,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [23:0]      m_tdata,  // payload_byte[7:0], payload_index[15:8], frame_length[23:16]
  output logic [1:0]       m_tuser   // status[1:0]
);
  import sld_pkg::*;

  logic    out_valid;
  logic    skid_valid;
  result_t out_res;
  result_t skid_res;
  logic    in_take;
  logic    out_take;

  assign in_ready = !skid_valid;
  assign in_take  = in_valid && in_ready;
  assign out_take = out_valid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take || !out_valid) begin
      // output slot free: drain skid first, else load new request
      if (skid_valid) begin
        out_res    <= skid_res;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (in_take) begin
        out_res   <= in_res;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (in_take) begin
      skid_res   <= in_res;
      skid_valid <= 1'b1;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_res.frame_length, out_res.payload_index, out_res.payload_byte};
  assign m_tuser  = out_res.status;

  `ASSERT_IMPL(a_skid_behind_out, skid_valid |-> out_valid)
  `ASSERT_NEXT(a_stall_fills_skid, in_take && out_valid && !m_tready, skid_valid)
  `ASSERT_NEXT(a_skid_drains, skid_valid && m_tready, out_valid && !skid_valid)

endmodule

@@ rtl/sync_length_xor_deframer_unit.sv @@
// Top level of the sync/length/xor deframer.
// Depends on sld_pkg, sld_core and sld_outbuf.
//
// Takes one received byte per request and returns one result per byte:
// it hunts for the four-byte sync word, reads a length byte and the
// delimiter, passes each payload byte with its index and reports frame
// good or checksum error on the check byte. One byte is accepted every
// cycle while s_tready is high; the frame state and the result are both
// registered on acceptance, the result in a two-entry output buffer that
// runs at full rate while m_tready stays high and still takes one more
// byte on a cycle where the master side stalls; s_tready drops only
// while both entries hold results. Configuration is written through
// cfg_we/cfg_index/cfg_data (index 0 sync word, index 1 delimiter).
module sync_length_xor_deframer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte[7:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // payload_byte[7:0], payload_index[15:8], frame_length[23:16]
  output logic [1:0]  m_tuser    // status[1:0]
);
  import sld_pkg::*;

  result_t core_res;
  logic    accept;

  assign accept = s_tvalid && s_tready;

  sld_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .in_byte   (s_tdata),
    .res       (core_res)
  );

  sld_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_res   (core_res),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
